FILE: rtl/weighted_round_robin_scheduler_unit_assert.svh
// Assertion shorthands for the scheduler. Each expects clk and arst_n in scope.
`ifndef WEIGHTED_ROUND_ROBIN_SCHEDULER_UNIT_ASSERT_SVH
`define WEIGHTED_ROUND_ROBIN_SCHEDULER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WRRS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WRRS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/wrrs_pkg.sv
package wrrs_pkg;

	// Default number of task slots.
	localparam int SLOTS_DEF = 16;

	// Field widths of the event and result beats.
	localparam int FUNC_W = 3;
	localparam int SLOT_W = 4;
	localparam int PRIO_W = 8;

	// Event codes.
	localparam logic [FUNC_W-1:0] FN_TICK    = 3'd0;
	localparam logic [FUNC_W-1:0] FN_ADD     = 3'd1;
	localparam logic [FUNC_W-1:0] FN_BLOCK   = 3'd2;
	localparam logic [FUNC_W-1:0] FN_UNBLOCK = 3'd3;
	localparam logic [FUNC_W-1:0] FN_REMOVE  = 3'd4;
	localparam logic [FUNC_W-1:0] FN_SETPRIO = 3'd5;
	localparam logic [FUNC_W-1:0] FN_YIELD   = 3'd6;

	// Slot states.
	localparam logic [1:0] ST_ABSENT  = 2'd0;
	localparam logic [1:0] ST_READY   = 2'd1;
	localparam logic [1:0] ST_RUNNING = 2'd2;
	localparam logic [1:0] ST_BLOCKED = 2'd3;

	// Result status codes.
	localparam logic RS_OK  = 1'b0;
	localparam logic RS_REJ = 1'b1;

	// One event beat.
	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [SLOT_W-1:0] slot;
		logic [PRIO_W-1:0] priority_req;
	} req_t;

	// One result beat.
	typedef struct packed {
		logic [SLOT_W-1:0] running_slot;
		logic              running_valid;
		logic              switched;
		logic              status;
	} rsp_t;

endpackage

FILE: rtl/wrrs_ram.sv
module wrrs_ram #(
	parameter int DEPTH = wrrs_pkg::SLOTS_DEF,
	parameter int WIDTH = wrrs_pkg::PRIO_W,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port and one read port; read data is registered.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/weighted_round_robin_scheduler_unit.sv
// Weighted round-robin task scheduler. An event beat is taken when start is high
// and busy is low; busy then stays high until the event is finished, and the
// result beat appears on rsp for exactly one cycle with rsp_valid high, in the
// cycle where busy has just dropped. The result cannot be held off, so it must be
// captured in that cycle. Add, unblock, set-priority and rejected events finish
// without walking the ring. Yield, and a tick that finds no running slot or whose
// running slot's quantum runs out, walk the ready ring to find the next ready slot;
// block and remove walk it to find the predecessor of the slot that leaves. Both
// walks read the ring link memory one entry per cycle, so those events stay busy while the walk runs.
`include "weighted_round_robin_scheduler_unit_assert.svh"

module weighted_round_robin_scheduler_unit #(
	parameter int SLOTS = wrrs_pkg::SLOTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  wrrs_pkg::req_t req,
	output logic          rsp_valid,
	output wrrs_pkg::rsp_t rsp
);

	import wrrs_pkg::*;

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

	typedef enum logic [9:0] {
		S_IDLE   = 10'b00_0000_0001,
		S_DECODE = 10'b00_0000_0010,
		S_TICKQ  = 10'b00_0000_0100,
		S_APPEND = 10'b00_0000_1000,
		S_UBLOAD = 10'b00_0001_0000,
		S_RMNEXT = 10'b00_0010_0000,
		S_RMWALK = 10'b00_0100_0000,
		S_SCAN   = 10'b00_1000_0000,
		S_RELOAD = 10'b01_0000_0000,
		S_DONE   = 10'b10_0000_0000
	} state_t;

	state_t state_q;

	// Ring and run state.
	logic [IW-1:0] head_q;
	logic [IW-1:0] tail_q;
	logic          empty_q;
	logic [IW-1:0] cursor_q;
	logic [IW-1:0] cur_q;
	logic          present_q;
	logic [1:0]    status_q [SLOTS];
	logic          member_q [SLOTS];

	// Event under work.
	logic [FUNC_W-1:0] func_q;
	logic [SLOT_W-1:0] s_q;
	logic [PRIO_W-1:0] prio_q;
	logic              rej_q;
	logic              old_valid_q;
	logic [IW-1:0]     old_slot_q;
	logic [IW-1:0]     start_q;
	logic [IW-1:0]     walk_q;
	logic [IW-1:0]     nxt_q;
	logic [IW-1:0]     cnt_q;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	// Decode helpers.
	logic [IW-1:0] s_idx;
	logic          in_range;
	logic [IW-1:0] st_idx;
	logic [1:0]    st_rd;
	logic          member_rd;
	logic          cmd_ok;
	logic          walk_found;

	// Memory ports.
	logic          nx_we;
	logic [IW-1:0] nx_waddr;
	logic [IW-1:0] nx_wdata;
	logic [IW-1:0] nx_raddr;
	logic [IW-1:0] nx_rdata;
	logic              pr_we;
	logic [IW-1:0]     pr_raddr;
	logic [PRIO_W-1:0] pr_rdata;
	logic              qu_we;
	logic [IW-1:0]     qu_waddr;
	logic [PRIO_W-1:0] qu_wdata;
	logic [PRIO_W-1:0] qu_rdata;

	assign s_idx     = IW'(s_q);
	assign in_range  = (int'(s_q) < SLOTS);
	assign member_rd = member_q[s_idx];
	assign st_rd     = status_q[st_idx];
	assign walk_found = (nx_rdata == s_idx) || (cnt_q == LAST);

	// The status table has a single read port; the state and the event code pick its address.
	always_comb begin
		st_idx = s_idx;
		if (state_q == S_SCAN) begin
			st_idx = nx_rdata;
		end else if (func_q == FN_TICK || func_q == FN_YIELD) begin
			st_idx = cur_q;
		end
	end

	// Acceptance check for the event, valid in the decode cycle.
	always_comb begin
		unique case (func_q)
			FN_TICK:    cmd_ok = 1'b1;
			FN_ADD:     cmd_ok = in_range && (st_rd == ST_ABSENT) && !member_rd;
			FN_BLOCK:   cmd_ok = in_range && (st_rd == ST_READY || st_rd == ST_RUNNING);
			FN_UNBLOCK: cmd_ok = in_range && (st_rd == ST_BLOCKED);
			FN_REMOVE:  cmd_ok = in_range && (st_rd != ST_ABSENT);
			FN_SETPRIO: cmd_ok = in_range && (st_rd != ST_ABSENT);
			FN_YIELD:   cmd_ok = present_q && (st_rd == ST_RUNNING);
			default:    cmd_ok = 1'b0;
		endcase
	end

	// Ring link memory control.
	always_comb begin
		nx_raddr = s_idx;
		nx_we    = 1'b0;
		nx_waddr = s_idx;
		nx_wdata = empty_q ? s_idx : head_q;
		unique case (state_q)
			S_DECODE: begin
				if (func_q == FN_TICK || func_q == FN_YIELD) begin
					nx_raddr = cursor_q;
				end
				nx_we = (func_q == FN_ADD) && cmd_ok;
			end
			S_TICKQ:  nx_raddr = cursor_q;
			S_UBLOAD: nx_we = !member_rd;
			S_APPEND: begin
				nx_we    = 1'b1;
				nx_waddr = tail_q;
				nx_wdata = s_idx;
			end
			S_RMNEXT: nx_raddr = head_q;
			S_SCAN:   nx_raddr = nx_rdata;
			S_RMWALK: begin
				nx_raddr = nx_rdata;
				if (walk_found) begin
					nx_we    = 1'b1;
					nx_waddr = walk_q;
					nx_wdata = nxt_q;
				end
			end
			default: ;
		endcase
	end

	// Priority and quantum memory control.
	always_comb begin
		pr_raddr = (state_q == S_SCAN) ? nx_rdata : s_idx;
		pr_we    = (state_q == S_DECODE) && cmd_ok &&
			(func_q == FN_ADD || func_q == FN_SETPRIO);
		qu_we    = 1'b0;
		qu_waddr = s_idx;
		qu_wdata = prio_q;
		unique case (state_q)
			S_DECODE: qu_we = cmd_ok &&
				((func_q == FN_ADD) || (func_q == FN_SETPRIO && member_rd));
			S_TICKQ: begin
				qu_we    = 1'b1;
				qu_waddr = cur_q;
				qu_wdata = (qu_rdata > PRIO_W'(1)) ? (qu_rdata - PRIO_W'(1)) : '0;
			end
			S_UBLOAD: begin
				qu_we    = 1'b1;
				qu_wdata = pr_rdata;
			end
			S_RELOAD: begin
				qu_we    = 1'b1;
				qu_waddr = cur_q;
				qu_wdata = pr_rdata;
			end
			default: ;
		endcase
	end

	wrrs_ram #(.DEPTH(SLOTS), .WIDTH(IW)) u_next (
		.clk   (clk),
		.we    (nx_we),
		.waddr (nx_waddr),
		.wdata (nx_wdata),
		.raddr (nx_raddr),
		.rdata (nx_rdata)
	);

	wrrs_ram #(.DEPTH(SLOTS), .WIDTH(PRIO_W)) u_prio (
		.clk   (clk),
		.we    (pr_we),
		.waddr (s_idx),
		.wdata (prio_q),
		.raddr (pr_raddr),
		.rdata (pr_rdata)
	);

	wrrs_ram #(.DEPTH(SLOTS), .WIDTH(PRIO_W)) u_quant (
		.clk   (clk),
		.we    (qu_we),
		.waddr (qu_waddr),
		.wdata (qu_wdata),
		.raddr (cur_q),
		.rdata (qu_rdata)
	);

	// Sequencer, ring pointers and slot state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			empty_q     <= 1'b1;
			cursor_q    <= '0;
			cur_q       <= '0;
			present_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < SLOTS; i++) begin
				status_q[i] <= ST_ABSENT;
				member_q[i] <= 1'b0;
			end
		end else begin
			rsp_valid_q <= (state_q == S_DONE);
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (!cmd_ok) begin
						state_q <= S_DONE;
					end else begin
						unique case (func_q)
							FN_TICK: begin
								if (empty_q) begin
									state_q <= S_DONE;
								end else if (present_q && st_rd == ST_RUNNING) begin
									state_q <= S_TICKQ;
								end else begin
									state_q <= S_SCAN;
								end
							end
							FN_ADD: begin
								status_q[s_idx] <= ST_READY;
								member_q[s_idx] <= 1'b1;
								if (empty_q) begin
									head_q   <= s_idx;
									tail_q   <= s_idx;
									cursor_q <= s_idx;
									empty_q  <= 1'b0;
									state_q  <= S_DONE;
								end else begin
									state_q <= S_APPEND;
								end
							end
							FN_BLOCK, FN_REMOVE: begin
								status_q[s_idx] <= (func_q == FN_BLOCK) ? ST_BLOCKED : ST_ABSENT;
								if (present_q && cur_q == s_idx) begin
									present_q <= 1'b0;
								end
								if (empty_q || !member_rd) begin
									state_q <= S_DONE;
								end else begin
									member_q[s_idx] <= 1'b0;
									state_q         <= S_RMNEXT;
								end
							end
							FN_UNBLOCK: begin
								status_q[s_idx] <= ST_READY;
								state_q         <= S_UBLOAD;
							end
							FN_YIELD: begin
								status_q[cur_q] <= ST_READY;
								state_q         <= S_SCAN;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_TICKQ: begin
					if (qu_rdata > PRIO_W'(1)) begin
						state_q <= S_DONE;
					end else begin
						status_q[cur_q] <= ST_READY;
						state_q         <= S_SCAN;
					end
				end
				S_UBLOAD: begin
					if (!member_rd) begin
						member_q[s_idx] <= 1'b1;
						if (empty_q) begin
							head_q   <= s_idx;
							tail_q   <= s_idx;
							cursor_q <= s_idx;
							empty_q  <= 1'b0;
							state_q  <= S_DONE;
						end else begin
							state_q <= S_APPEND;
						end
					end else begin
						state_q <= S_DONE;
					end
				end
				S_APPEND: begin
					tail_q  <= s_idx;
					state_q <= S_DONE;
				end
				S_RMNEXT: begin
					if (nx_rdata == s_idx) begin
						empty_q  <= 1'b1;
						head_q   <= '0;
						tail_q   <= '0;
						cursor_q <= '0;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_RMWALK;
					end
				end
				S_RMWALK: begin
					if (walk_found) begin
						if (head_q == s_idx) begin
							head_q <= nxt_q;
						end
						if (tail_q == s_idx) begin
							tail_q <= walk_q;
						end
						if (cursor_q == s_idx) begin
							cursor_q <= nxt_q;
						end
						state_q <= S_DONE;
					end
				end
				S_SCAN: begin
					if (st_rd == ST_READY) begin
						cursor_q           <= nx_rdata;
						cur_q              <= nx_rdata;
						present_q          <= 1'b1;
						status_q[nx_rdata] <= ST_RUNNING;
						state_q            <= S_RELOAD;
					end else if (nx_rdata == start_q || cnt_q == LAST) begin
						present_q <= 1'b0;
						state_q   <= S_DONE;
					end
				end
				S_RELOAD: state_q <= S_DONE;
				S_DONE:   state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	// Event fields, walk registers and the result beat.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					func_q      <= req.func;
					s_q         <= req.slot;
					prio_q      <= (req.priority_req == '0) ? PRIO_W'(1) : req.priority_req;
					old_valid_q <= present_q;
					old_slot_q  <= cur_q;
				end
			end
			S_DECODE: begin
				rej_q   <= cmd_ok ? RS_OK : RS_REJ;
				start_q <= cursor_q;
				cnt_q   <= '0;
			end
			S_TICKQ: begin
				start_q <= cursor_q;
				cnt_q   <= '0;
			end
			S_RMNEXT: begin
				nxt_q  <= nx_rdata;
				walk_q <= head_q;
				cnt_q  <= '0;
			end
			S_RMWALK: begin
				walk_q <= nx_rdata;
				cnt_q  <= cnt_q + IW'(1);
			end
			S_SCAN: cnt_q <= cnt_q + IW'(1);
			S_DONE: begin
				rsp_q.running_slot  <= present_q ? SLOT_W'(cur_q) : '0;
				rsp_q.running_valid <= present_q;
				rsp_q.switched      <= (present_q != old_valid_q) ||
					(present_q && old_slot_q != cur_q);
				rsp_q.status        <= rej_q;
			end
			default: ;
		endcase
	end

	assign busy      = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// A result appears only once the block is free again.
	`WRRS_ASSERT_SAME(a_rsp_not_busy, rsp_valid, !busy, "result strobe while busy")
	// Each event yields a single one-cycle result.
	`WRRS_ASSERT_NEXT(a_rsp_single, rsp_valid, !rsp_valid, "result strobe held over two cycles")
	// An accepted event occupies the block before any result.
	`WRRS_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !rsp_valid, "accepted event not in work")
	// An idle result reports slot zero.
	`WRRS_ASSERT_SAME(a_idle_slot, rsp_valid && !rsp.running_valid, rsp.running_slot == '0, "idle result with nonzero slot")
	// Nothing runs while the ring is empty.
	`WRRS_ASSERT_SAME(a_empty_idle, state_q == S_IDLE && empty_q, !present_q, "slot running on an empty ring")

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import wrrs_pkg::*;

	localparam int NSLOT = SLOTS_DEF;
	localparam logic [FUNC_W-1:0] FN_UNKNOWN = 3'd7;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = NSLOT + 8;
	localparam int PHASE_BEATS = 333;

	// Mirror of the scheduler state, the queue of responses still due, and the checks.
	class slot_schedule;
		logic [1:0] slot_state [NSLOT];
		logic [7:0] prio [NSLOT];
		logic [7:0] quantum [NSLOT];
		logic [3:0] link [NSLOT];
		bit on_ring [NSLOT];
		logic [3:0] head;
		logic [3:0] tail;
		logic [3:0] cursor;
		logic [3:0] cur_slot;
		bit ring_vacant;
		bit running;
		rsp_t due_responses [$];
		int mismatches;
		int results;
		int rejects;
		int switches;
		int func_count [8];

		function new();
			for (int i = 0; i < NSLOT; i++) begin
				slot_state[i] = ST_ABSENT;
				prio[i] = 8'd0;
				quantum[i] = 8'd0;
				link[i] = 4'd0;
				on_ring[i] = 1'b0;
			end
			for (int i = 0; i < 8; i++) begin
				func_count[i] = 0;
			end
			head = 4'd0;
			tail = 4'd0;
			cursor = 4'd0;
			cur_slot = 4'd0;
			ring_vacant = 1'b1;
			running = 1'b0;
			mismatches = 0;
			results = 0;
			rejects = 0;
			switches = 0;
		endfunction

		// A requested quantum of zero behaves as one tick.
		function logic [7:0] quantum_of(logic [7:0] p);
			return (p == 8'd0) ? 8'd1 : p;
		endfunction

		// Appending links the slot behind the tail; the first member also takes the cursor.
		function void ring_append(logic [3:0] s);
			if (ring_vacant) begin
				head = s;
				tail = s;
				link[s] = s;
				cursor = s;
				ring_vacant = 1'b0;
			end else begin
				link[tail] = s;
				link[s] = head;
				tail = s;
			end
			on_ring[s] = 1'b1;
		endfunction

		// Unlinking finds the predecessor by walking from the head.
		function void ring_unlink(logic [3:0] s);
			logic [3:0] nxt;
			logic [3:0] p;
			if (ring_vacant || !on_ring[s]) begin
				return;
			end
			on_ring[s] = 1'b0;
			nxt = link[s];
			if (nxt == s) begin
				ring_vacant = 1'b1;
				head = 4'd0;
				tail = 4'd0;
				cursor = 4'd0;
				return;
			end
			p = head;
			for (int i = 0; i < NSLOT; i++) begin
				if (link[p] == s) begin
					break;
				end
				p = link[p];
			end
			link[p] = nxt;
			if (head == s) begin
				head = nxt;
			end
			if (tail == s) begin
				tail = p;
			end
			if (cursor == s) begin
				cursor = nxt;
			end
		endfunction

		// The scan starts after the cursor and goes at most once around the ring.
		function void select_next();
			logic [3:0] first;
			logic [3:0] n;
			first = cursor;
			n = first;
			for (int i = 0; i < NSLOT; i++) begin
				n = link[n];
				if (slot_state[n] == ST_READY) begin
					cursor = n;
					cur_slot = n;
					running = 1'b1;
					slot_state[n] = ST_RUNNING;
					quantum[n] = prio[n];
					return;
				end
				if (n == first) begin
					break;
				end
			end
			running = 1'b0;
		endfunction

		// Applies one accepted event and queues the response it must produce.
		function void note_event(req_t e);
			rsp_t want;
			bit was_running;
			logic [3:0] was_slot;
			logic [3:0] s;
			logic [3:0] cs;
			bit rej;
			was_running = running;
			was_slot = cur_slot;
			s = e.slot;
			cs = cur_slot;
			rej = 1'b0;
			func_count[e.func]++;
			case (e.func)
				FN_TICK: begin
					if (!ring_vacant) begin
						if (running && slot_state[cs] == ST_RUNNING && quantum[cs] > 8'd1) begin
							quantum[cs] = quantum[cs] - 8'd1;
						end else begin
							if (running && slot_state[cs] == ST_RUNNING) begin
								quantum[cs] = 8'd0;
								slot_state[cs] = ST_READY;
							end
							select_next();
						end
					end
				end
				FN_ADD: begin
					if (slot_state[s] != ST_ABSENT || on_ring[s]) begin
						rej = 1'b1;
					end else begin
						prio[s] = quantum_of(e.priority_req);
						quantum[s] = prio[s];
						slot_state[s] = ST_READY;
						ring_append(s);
					end
				end
				FN_BLOCK: begin
					if (slot_state[s] != ST_READY && slot_state[s] != ST_RUNNING) begin
						rej = 1'b1;
					end else begin
						slot_state[s] = ST_BLOCKED;
						ring_unlink(s);
						if (running && cs == s) begin
							running = 1'b0;
						end
					end
				end
				FN_UNBLOCK: begin
					if (slot_state[s] != ST_BLOCKED) begin
						rej = 1'b1;
					end else begin
						slot_state[s] = ST_READY;
						quantum[s] = prio[s];
						if (!on_ring[s]) begin
							ring_append(s);
						end
					end
				end
				FN_REMOVE: begin
					if (slot_state[s] == ST_ABSENT) begin
						rej = 1'b1;
					end else begin
						ring_unlink(s);
						slot_state[s] = ST_ABSENT;
						if (running && cs == s) begin
							running = 1'b0;
						end
					end
				end
				FN_SETPRIO: begin
					if (slot_state[s] == ST_ABSENT) begin
						rej = 1'b1;
					end else begin
						prio[s] = quantum_of(e.priority_req);
						if (on_ring[s]) begin
							quantum[s] = prio[s];
						end
					end
				end
				FN_YIELD: begin
					if (!running || slot_state[cs] != ST_RUNNING) begin
						rej = 1'b1;
					end else begin
						slot_state[cs] = ST_READY;
						select_next();
					end
				end
				default: begin
					rej = 1'b1;
				end
			endcase
			want.running_valid = running;
			want.running_slot = running ? cur_slot : 4'd0;
			want.switched = (running != was_running) || (running && was_slot != cur_slot);
			want.status = rej ? RS_REJ : RS_OK;
			if (rej) begin
				rejects++;
			end
			if (want.switched) begin
				switches++;
			end
			due_responses.push_back(want);
		endfunction

		// Picks a slot whose state is set in the accept mask, from a random starting point.
		function bit find_slot(logic [3:0] accept, output logic [3:0] s);
			int first;
			int idx;
			first = $urandom_range(0, NSLOT - 1);
			for (int i = 0; i < NSLOT; i++) begin
				idx = (first + i) % NSLOT;
				if (accept[slot_state[idx]]) begin
					s = 4'(idx);
					return 1'b1;
				end
			end
			s = 4'd0;
			return 1'b0;
		endfunction

		function int pending();
			return due_responses.size();
		endfunction

		task report_miss(string what);
			mismatches++;
			if (mismatches <= 40) begin
				$display("MISMATCH @%0t: %s", $time, what);
			end
		endtask

		// Compares a result beat with the oldest response still due.
		task check_result(rsp_t got);
			rsp_t want;
			results++;
			if (due_responses.size() == 0) begin
				report_miss($sformatf("result beat slot=%0d valid=%0b sw=%0b st=%0b with none due",
					got.running_slot, got.running_valid, got.switched, got.status));
				return;
			end
			want = due_responses.pop_front();
			if (got.running_slot !== want.running_slot) begin
				report_miss($sformatf("beat %0d running_slot got %0d want %0d",
					results, got.running_slot, want.running_slot));
			end
			if (got.running_valid !== want.running_valid) begin
				report_miss($sformatf("beat %0d running_valid got %0b want %0b",
					results, got.running_valid, want.running_valid));
			end
			if (got.switched !== want.switched) begin
				report_miss($sformatf("beat %0d switched got %0b want %0b",
					results, got.switched, want.switched));
			end
			if (got.status !== want.status) begin
				report_miss($sformatf("beat %0d status got %0b want %0b",
					results, got.status, want.status));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic busy;
	logic rsp_valid;
	rsp_t rsp;
	int cycles = 0;
	slot_schedule schedule;

	weighted_round_robin_scheduler_unit #(
		.SLOTS(NSLOT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	// Run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d responses still due",
				cycles, schedule.pending());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Result beats cannot be held off, so every strobed cycle is checked.
	always @(posedge clk) begin
		if (arst_n && rsp_valid) begin
			schedule.check_result(rsp);
		end
	end

	function automatic req_t make_event(logic [FUNC_W-1:0] f, logic [SLOT_W-1:0] s,
		logic [PRIO_W-1:0] p);
		req_t e;
		e.func = f;
		e.slot = s;
		e.priority_req = p;
		return e;
	endfunction

	// Holds the beat on the bus until an edge sees start high and busy low.
	task automatic send_event(req_t e);
		start <= 1'b1;
		req <= e;
		do begin
			@(posedge clk);
		end while (busy);
		schedule.note_event(e);
	endtask

	// Sender gap of random length, so that gaps fall on every cycle of the block's work.
	task automatic idle_maybe(int pct);
		if ($urandom_range(0, 99) < pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, NSLOT + 6)) @(posedge clk);
		end
	endtask

	// Stops sending until every response due has come back.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (schedule.pending() != 0) begin
			@(posedge clk);
		end
	endtask

	// Mostly well-formed events aimed at slots in a state that accepts them.
	function automatic req_t draw_event();
		req_t e;
		int pick;
		logic [3:0] accept;
		logic [3:0] s;
		bit found;
		pick = $urandom_range(0, 99);
		accept = 4'b0000;
		if (pick < 35) begin
			e.func = FN_TICK;
		end else if (pick < 50) begin
			e.func = FN_ADD;
			accept = 4'b0001;
		end else if (pick < 60) begin
			e.func = FN_BLOCK;
			accept = 4'b0110;
		end else if (pick < 70) begin
			e.func = FN_UNBLOCK;
			accept = 4'b1000;
		end else if (pick < 77) begin
			e.func = FN_REMOVE;
			accept = 4'b1110;
		end else if (pick < 85) begin
			e.func = FN_SETPRIO;
			accept = 4'b1110;
		end else if (pick < 97) begin
			e.func = FN_YIELD;
		end else begin
			e.func = FN_UNKNOWN;
		end
		e.slot = 4'($urandom_range(0, NSLOT - 1));
		if (accept != 4'b0000 && $urandom_range(0, 99) < 85) begin
			found = schedule.find_slot(accept, s);
			if (found) begin
				e.slot = s;
			end
		end
		// Short quanta keep the rotation busy; zero and full-range values appear too.
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			e.priority_req = 8'($urandom_range(1, 4));
		end else if (pick < 85) begin
			e.priority_req = 8'd0;
		end else begin
			e.priority_req = 8'($urandom);
		end
		return e;
	endfunction

	initial begin
		int phase_idle [3];
		req_t e;
		phase_idle = '{0, 70, 13};
		schedule = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening: empty ring, idle yield, unknown code, quantum expiry,
		// rejects of every kind, blocking the running slot and emptying the ring.
		send_event(make_event(FN_TICK, 4'd0, 8'd0));
		send_event(make_event(FN_YIELD, 4'd0, 8'd0));
		send_event(make_event(FN_UNKNOWN, 4'd15, 8'hff));
		send_event(make_event(FN_ADD, 4'd0, 8'd0));
		send_event(make_event(FN_TICK, 4'd0, 8'd0));
		send_event(make_event(FN_ADD, 4'd15, 8'hff));
		send_event(make_event(FN_ADD, 4'd15, 8'd1));
		send_event(make_event(FN_TICK, 4'd0, 8'd0));
		send_event(make_event(FN_TICK, 4'd0, 8'd0));
		send_event(make_event(FN_YIELD, 4'd0, 8'd0));
		send_event(make_event(FN_SETPRIO, 4'd15, 8'd2));
		send_event(make_event(FN_BLOCK, 4'd15, 8'd0));
		send_event(make_event(FN_UNBLOCK, 4'd15, 8'd0));
		send_event(make_event(FN_UNBLOCK, 4'd15, 8'd0));
		send_event(make_event(FN_BLOCK, 4'd0, 8'd0));
		send_event(make_event(FN_TICK, 4'd0, 8'd0));
		send_event(make_event(FN_SETPRIO, 4'd7, 8'd9));
		send_event(make_event(FN_REMOVE, 4'd3, 8'd0));
		send_event(make_event(FN_BLOCK, 4'd9, 8'd0));
		send_event(make_event(FN_ADD, 4'd7, 8'h80));
		send_event(make_event(FN_REMOVE, 4'd15, 8'd0));
		send_event(make_event(FN_SETPRIO, 4'd0, 8'd0));
		send_event(make_event(FN_REMOVE, 4'd0, 8'd0));
		send_event(make_event(FN_YIELD, 4'd0, 8'd0));
		send_event(make_event(FN_REMOVE, 4'd7, 8'd0));
		send_event(make_event(FN_TICK, 4'd0, 8'd0));
		drain();

		// Random phases: back to back, sparse sender, light sender gaps.
		for (int ph = 0; ph < 3; ph++) begin
			for (int n = 0; n < PHASE_BEATS; n++) begin
				e = draw_event();
				send_event(e);
				idle_maybe(phase_idle[ph]);
			end
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (schedule.pending() != 0) begin
			schedule.report_miss($sformatf("%0d responses never arrived", schedule.pending()));
		end

		$display("Checked %0d result beats over %0d cycles: %0d rejected, %0d slot switches.",
			schedule.results, cycles, schedule.rejects, schedule.switches);
		$display("Events: tick %0d, add %0d, block %0d, unblock %0d, ",
			schedule.func_count[FN_TICK], schedule.func_count[FN_ADD],
			schedule.func_count[FN_BLOCK], schedule.func_count[FN_UNBLOCK],
			"remove %0d, prio %0d, yield %0d, bad %0d.",
			schedule.func_count[FN_REMOVE], schedule.func_count[FN_SETPRIO],
			schedule.func_count[FN_YIELD], schedule.func_count[FN_UNKNOWN]);
		if (schedule.mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

FILE: weighted_round_robin_scheduler_unit.f
+incdir+rtl
rtl/wrrs_pkg.sv
rtl/wrrs_ram.sv
rtl/weighted_round_robin_scheduler_unit.sv
bench/tb_top.sv
